// File: hdl/kbs_pkg.sv
package kbs_pkg;

  localparam int MAX_KEYS  = 256;
  localparam int TIME_BITS = 24;
  localparam int IDX_BITS  = $clog2(MAX_KEYS);
  localparam int CNT_BITS  = 9;
  localparam int FRAC_BITS = 16;
  localparam int CMD_DEPTH = 2;

  localparam logic [FRAC_BITS:0] FRAC_ONE = (FRAC_BITS + 1)'(1 << FRAC_BITS);

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_QUERY,
    OP_DROP
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [IDX_BITS-1:0]  idx;
    logic [TIME_BITS-1:0] stamp;
  } cmd_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]  lower;
    logic [IDX_BITS-1:0]  upper;
    logic [FRAC_BITS:0]   frac;
    logic                 past;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LAST,
    BK_SEARCH,
    BK_TLO,
    BK_THI,
    BK_DIV,
    BK_DONE
  } back_state_e;

endpackage

// File: hdl/kbs_front.sv
module kbs_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic                            fifo_full_i,
  input  logic                            action_i,
  input  logic [7:0]                      key_index_i,
  input  logic [23:0]                     key_time_i,
  input  logic [23:0]                     query_time_i,
  input  logic                            key_count_we_i,
  input  logic [kbs_pkg::CNT_BITS-1:0]    key_count_i,
  output logic                            enq_o,
  output kbs_pkg::cmd_t                   cmd_o,
  output logic [kbs_pkg::IDX_BITS-1:0]    last_idx_o
);
  import kbs_pkg::*;

  logic [IDX_BITS-1:0] last_q, last_d;

  // classify: out-of-table writes are swallowed here
  always_comb begin
    cmd_o.idx = IDX_BITS'(key_index_i);
    if (action_i) begin
      cmd_o.op    = OP_QUERY;
      cmd_o.stamp = query_time_i;
    end else begin
      cmd_o.op    = (32'(key_index_i) >= MAX_KEYS) ? OP_DROP : OP_WRITE;
      cmd_o.stamp = key_time_i;
    end
  end

  assign enq_o = push_i && !fifo_full_i && (cmd_o.op != OP_DROP);

  // key count clamped to 1..MAX_KEYS, kept as last index
  always_comb begin
    if (key_count_i == '0) begin
      last_d = '0;
    end else if (32'(key_count_i) > MAX_KEYS) begin
      last_d = IDX_BITS'(MAX_KEYS - 1);
    end else begin
      last_d = IDX_BITS'(key_count_i - CNT_BITS'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (key_count_we_i) begin
      last_q <= last_d;
    end
  end

  assign last_idx_o = last_q;

endmodule

// File: hdl/kbs_cmd_fifo.sv
module kbs_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          enq_i,
  input  kbs_pkg::cmd_t enq_word_i,
  output logic          full_o,
  input  logic          deq_i,
  output logic          valid_o,
  output kbs_pkg::cmd_t deq_word_o
);
  import kbs_pkg::*;

  localparam int PTR_BITS = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int LVL_BITS = $clog2(CMD_DEPTH + 1);

  cmd_t                entry_q [CMD_DEPTH];
  logic [PTR_BITS-1:0] wr_q, rd_q;
  logic [LVL_BITS-1:0] lvl_q;
  logic                do_enq, do_deq;

  assign full_o     = (lvl_q == LVL_BITS'(CMD_DEPTH));
  assign valid_o    = (lvl_q != '0);
  assign deq_word_o = entry_q[rd_q];
  assign do_enq     = enq_i && !full_o;
  assign do_deq     = deq_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      entry_q[wr_q] <= enq_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      if (do_enq) begin
        wr_q <= (32'(wr_q) == CMD_DEPTH - 1) ? '0 : wr_q + PTR_BITS'(1);
      end
      if (do_deq) begin
        rd_q <= (32'(rd_q) == CMD_DEPTH - 1) ? '0 : rd_q + PTR_BITS'(1);
      end
      if (do_enq && !do_deq) begin
        lvl_q <= lvl_q + LVL_BITS'(1);
      end else if (do_deq && !do_enq) begin
        lvl_q <= lvl_q - LVL_BITS'(1);
      end
    end
  end

endmodule

// File: hdl/kbs_div.sv
module kbs_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [kbs_pkg::TIME_BITS-1:0]  num_i,
  input  logic [kbs_pkg::TIME_BITS-1:0]  den_i,
  output logic                           done_o,
  output logic [kbs_pkg::FRAC_BITS-1:0]  quo_o
);
  import kbs_pkg::*;

  localparam int STEP_BITS = $clog2(FRAC_BITS + 1);

  logic [TIME_BITS-1:0] rem_q, den_q;
  logic [FRAC_BITS-1:0] quo_q;
  logic [STEP_BITS-1:0] cnt_q;
  logic                 done_q;
  logic [TIME_BITS:0]   shifted, diff;
  logic                 fits;

  // one restoring step per cycle; remainder stays below den
  assign shifted = {rem_q, 1'b0};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = (shifted >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
      quo_q <= {quo_q[FRAC_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == STEP_BITS'(1)) && !start_i;
      if (start_i) begin
        cnt_q <= STEP_BITS'(FRAC_BITS);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - STEP_BITS'(1);
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: hdl/kbs_back.sv
module kbs_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  kbs_pkg::cmd_t                 cmd_i,
  output logic                          cmd_pop_o,
  input  logic [kbs_pkg::IDX_BITS-1:0]  last_idx_i,
  input  logic                          pop_i,
  output logic                          res_valid_o,
  output kbs_pkg::res_t                 res_o
);
  import kbs_pkg::*;

  back_state_e state_q, state_d;

  logic [TIME_BITS-1:0] key_mem [MAX_KEYS];
  logic [TIME_BITS-1:0] rdata_q;
  logic [IDX_BITS-1:0]  rd_addr, mid_q;
  logic                 mem_we;

  logic [TIME_BITS-1:0] q_q, q_d, tl_q, tl_d;
  logic [IDX_BITS-1:0]  lo_q, lo_d, hi_q, hi_d, up_q, up_d;
  logic [FRAC_BITS:0]   frac_q, frac_d;
  logic                 past_q, past_d;
  res_t                 res_q;
  logic                 res_valid_q, res_load;

  logic [IDX_BITS-1:0]  lo_n, hi_n;
  logic                 hit;
  logic [IDX_BITS:0]    mid_sum;
  logic [TIME_BITS-1:0] num, den;
  logic                 div_start, div_done;
  logic [FRAC_BITS-1:0] div_quo;

  assign num = q_q - tl_q;
  assign den = rdata_q - tl_q;

  kbs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // key table, at most one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[cmd_i.idx] <= cmd_i.stamp;
    end
    rdata_q <= key_mem[rd_addr];
    mid_q   <= rd_addr;
  end

  always_comb begin
    state_d   = state_q;
    q_d       = q_q;
    tl_d      = tl_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    up_d      = up_q;
    frac_d    = frac_q;
    past_d    = past_q;
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    res_load  = 1'b0;
    rd_addr   = lo_q;
    lo_n      = lo_q;
    hi_n      = hi_q;
    hit       = 1'b0;
    mid_sum   = '0;
    case (state_q)
      BK_IDLE: begin
        rd_addr = last_idx_i;
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.op == OP_WRITE) begin
            mem_we = 1'b1;
          end else if (cmd_i.op == OP_QUERY) begin
            q_d     = cmd_i.stamp;
            state_d = BK_LAST;
          end
        end
      end
      BK_LAST: begin
        past_d = (q_q >= rdata_q);
        if ((q_q >= rdata_q) || (last_idx_i == '0)) begin
          lo_d    = last_idx_i;
          up_d    = last_idx_i;
          frac_d  = FRAC_ONE;
          state_d = BK_DONE;
        end else begin
          lo_d = '0;
          hi_d = last_idx_i;
          if (last_idx_i == IDX_BITS'(1)) begin
            rd_addr = '0;
            state_d = BK_TLO;
          end else begin
            rd_addr = last_idx_i >> 1;
            state_d = BK_SEARCH;
          end
        end
      end
      BK_SEARCH: begin
        if (rdata_q < q_q) begin
          lo_n = mid_q;
        end else if (rdata_q > q_q) begin
          hi_n = mid_q;
        end else begin
          lo_n = mid_q;
          hit  = 1'b1;
        end
        lo_d    = lo_n;
        hi_d    = hi_n;
        mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
        if (hit || (hi_n - lo_n <= IDX_BITS'(1))) begin
          rd_addr = lo_n;
          state_d = BK_TLO;
        end else begin
          rd_addr = mid_sum[IDX_BITS:1];
        end
      end
      BK_TLO: begin
        tl_d    = rdata_q;
        rd_addr = lo_q + IDX_BITS'(1);
        up_d    = lo_q + IDX_BITS'(1);
        state_d = BK_THI;
      end
      BK_THI: begin
        state_d = BK_DONE;
        if (q_q < tl_q) begin
          frac_d = '0;
        end else if (rdata_q <= tl_q) begin
          frac_d = FRAC_ONE;
        end else if (num >= den) begin
          frac_d = FRAC_ONE;
        end else begin
          div_start = 1'b1;
          state_d   = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          frac_d  = {1'b0, div_quo};
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!res_valid_q || pop_i) begin
          res_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    q_d_reg: begin
      q_q    <= q_d;
      tl_q   <= tl_d;
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      up_q   <= up_d;
      frac_q <= frac_d;
      past_q <= past_d;
    end
    if (res_load) begin
      res_q.lower <= lo_q;
      res_q.upper <= up_q;
      res_q.frac  <= frac_q;
      res_q.past  <= past_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // search window never collapses while probing
  a_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SEARCH) |-> ((hi_q > lo_q) && (hi_q - lo_q != IDX_BITS'(1))))
    else $error("search window too narrow");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == BK_DIV))
    else $error("divider finished outside divide state");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DONE) |-> (frac_q <= FRAC_ONE))
    else $error("fraction above one");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !pop_i) |=> (res_valid_q && $stable(res_q)))
    else $error("waiting result lost or changed");

endmodule

// File: hdl/keyframe_bracket_search.sv
// Channel   Direction  Handshake               Payload
// --------  ---------  ----------------------  -------------------------------------------
// input     in         push_i / full_o         action_i key_index_i key_time_i query_time_i
// result    out        pop_i / empty_o         lower_index_o upper_index_o fraction_o past_end_o
// config    in         key_count_we_i          key_count_i
//
// A key write is stored in the back end as it leaves the queue. The time a query takes
// is set by the binary search (one read of the key table per step, up to 8 steps) and
// the restoring divider for the fraction.
// A 2-word command queue decouples intake from the back end; a result register
// holds the finished word so the back end moves on while it waits for pop_i.
// Reset clears control state only; key table contents are undefined until written.
module keyframe_bracket_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic        action_i,
  input  logic [7:0]  key_index_i,
  input  logic [23:0] key_time_i,
  input  logic [23:0] query_time_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [7:0]  lower_index_o,
  output logic [7:0]  upper_index_o,
  output logic [16:0] fraction_o,
  output logic        past_end_o,
  input  logic        key_count_we_i,
  input  logic [8:0]  key_count_i
);
  import kbs_pkg::*;

  logic                fifo_full;
  logic                enq;
  cmd_t                enq_word;
  logic                cmd_valid;
  cmd_t                cmd_word;
  logic                cmd_pop;
  logic [IDX_BITS-1:0] last_idx;
  logic                res_valid;
  res_t                res;

  // front end: intake, write filtering, key count register
  kbs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .fifo_full_i    (fifo_full),
    .action_i       (action_i),
    .key_index_i    (key_index_i),
    .key_time_i     (key_time_i),
    .query_time_i   (query_time_i),
    .key_count_we_i (key_count_we_i),
    .key_count_i    (key_count_i),
    .enq_o          (enq),
    .cmd_o          (enq_word),
    .last_idx_o     (last_idx)
  );

  kbs_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .enq_i      (enq),
    .enq_word_i (enq_word),
    .full_o     (fifo_full),
    .deq_i      (cmd_pop),
    .valid_o    (cmd_valid),
    .deq_word_o (cmd_word)
  );

  // back end: key table, search sequencer, divider, result register
  kbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_word),
    .cmd_pop_o   (cmd_pop),
    .last_idx_i  (last_idx),
    .pop_i       (pop_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign full_o        = fifo_full;
  assign empty_o       = !res_valid;
  assign lower_index_o = res.lower;
  assign upper_index_o = res.upper;
  assign fraction_o    = res.frac;
  assign past_end_o    = res.past;

endmodule
